// File: design/kmp_pkg.sv
`default_nettype none

package kmp_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int POS_WIDTH   = 32;
  localparam int ADDR_W      = $clog2(MAX_PATTERN);
  localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
  localparam int START_W     = 32;

  localparam logic [1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [1:0] FUNC_APPEND  = 2'd1;
  localparam logic [1:0] FUNC_TEXT    = 2'd2;
  localparam logic [1:0] FUNC_RESTART = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_in;
  } kmp_in_t;

  typedef struct packed {
    logic               match_found;
    logic [START_W-1:0] match_start;
    logic [1:0]         status;
  } kmp_out_t;

endpackage

`default_nettype wire

// File: design/kmp_ram.sv
`default_nettype none

module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/kmp_stream_matcher.sv
// results: clear, restart, dropped, empty-pattern and first-pattern-byte items finish from the idle
//   state; other text and pattern items pass through the compare state, following one link per step
// throughput: one item in flight; the input stalls while a text or pattern item walks the fallback
//   loop, which reads the pattern and failure memories at each step, and while a result waits
// reset: synchronous, active low; clears counts, match lengths, text position and the output valid flag,
//   the pattern and failure memories are not cleared (only written entries are ever used)
`default_nettype none

module kmp_stream_matcher
  import kmp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire kmp_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output kmp_out_t      out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic                 is_text_r, is_text_nxt;
  logic [7:0]           ch_r, ch_nxt;
  logic [ADDR_W-1:0]    len_r, len_nxt;
  logic [CNT_W-1:0]     pc_r, pc_nxt;
  logic [ADDR_W-1:0]    bl_r, bl_nxt;
  logic [ADDR_W-1:0]    tml_r, tml_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  kmp_out_t             hold_r, hold_nxt;
  logic                 out_valid_r, out_valid_nxt;
  kmp_out_t             out_data_r, out_data_nxt;

  logic              p_we, f_we;
  logic [ADDR_W-1:0] p_waddr, f_waddr, f_wdata, rd_len, f_raddr;
  logic [7:0]        p_wdata, p_rdata;
  logic [ADDR_W-1:0] f_rdata;

  logic                 fin, out_free, hit;
  kmp_out_t             fin_data;
  logic [CNT_W-1:0]     j;
  logic [ADDR_W-1:0]    tml_eff;
  logic [POS_WIDTH-1:0] start_pos;

  kmp_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pattern (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (rd_len),
    .rdata (p_rdata)
  );

  kmp_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_PATTERN)) u_failure (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  assign f_raddr   = rd_len - ADDR_W'(1);
  assign out_free  = !out_valid_r || !out_stall;
  assign hit       = (p_rdata == ch_r);
  assign j         = {1'b0, len_r} + CNT_W'(hit);
  assign tml_eff   = ({1'b0, tml_r} >= pc_r) ? '0 : tml_r;
  assign start_pos = pos_r - POS_WIDTH'(pc_r) + POS_WIDTH'(1);

  always_comb begin
    state_nxt     = state_r;
    is_text_nxt   = is_text_r;
    ch_nxt        = ch_r;
    len_nxt       = len_r;
    pc_nxt        = pc_r;
    bl_nxt        = bl_r;
    tml_nxt       = tml_r;
    pos_nxt       = pos_r;
    hold_nxt      = hold_r;
    p_we          = 1'b0;
    p_waddr       = pc_r[ADDR_W-1:0];
    p_wdata       = in_data.char_in;
    f_we          = 1'b0;
    f_waddr       = pc_r[ADDR_W-1:0];
    f_wdata       = '0;
    rd_len        = f_rdata;
    fin           = 1'b0;
    fin_data      = '0;

    unique case (state_r)
      ST_IDLE: begin
        rd_len = (in_data.func == FUNC_TEXT) ? tml_eff : bl_r;
        if (in_valid) begin
          unique case (in_data.func)
            FUNC_CLEAR: begin
              pc_nxt  = '0;
              bl_nxt  = '0;
              tml_nxt = '0;
              pos_nxt = '0;
              fin     = 1'b1;
            end
            FUNC_APPEND: begin
              if (pc_r == CNT_W'(MAX_PATTERN)) begin
                fin             = 1'b1;
                fin_data.status = STAT_FULL;
              end else if (pc_r == '0) begin
                p_we   = 1'b1;
                f_we   = 1'b1;
                bl_nxt = '0;
                pc_nxt = CNT_W'(1);
                fin    = 1'b1;
              end else begin
                p_we        = 1'b1;
                is_text_nxt = 1'b0;
                ch_nxt      = in_data.char_in;
                len_nxt     = bl_r;
                state_nxt   = ST_CMP;
              end
            end
            FUNC_TEXT: begin
              if (pc_r == '0) begin
                fin             = 1'b1;
                fin_data.status = STAT_EMPTY;
              end else begin
                is_text_nxt = 1'b1;
                ch_nxt      = in_data.char_in;
                len_nxt     = tml_eff;
                state_nxt   = ST_CMP;
              end
            end
            FUNC_RESTART: begin
              tml_nxt = '0;
              pos_nxt = '0;
              fin     = 1'b1;
            end
            default: ;
          endcase
        end
      end

      ST_CMP: begin
        if (len_r == '0 || hit) begin
          // fallback loop ends here
          state_nxt = ST_IDLE;
          fin       = 1'b1;
          if (is_text_r) begin
            pos_nxt = pos_r + POS_WIDTH'(1);
            if (j == pc_r) begin
              fin_data.match_found = 1'b1;
              fin_data.match_start = START_W'(start_pos);
              tml_nxt              = bl_r;
            end else begin
              tml_nxt = j[ADDR_W-1:0];
            end
          end else begin
            f_we    = 1'b1;
            f_wdata = j[ADDR_W-1:0];
            bl_nxt  = j[ADDR_W-1:0];
            pc_nxt  = pc_r + CNT_W'(1);
          end
        end else begin
          len_nxt = f_rdata;
        end
      end

      ST_WAIT: begin
        fin      = 1'b1;
        fin_data = hold_r;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // park the result when the output register is still occupied
    if (fin && !out_free && state_r != ST_WAIT) begin
      hold_nxt  = fin_data;
      state_nxt = ST_WAIT;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (fin && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = fin_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      bl_r        <= '0;
      tml_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      bl_r        <= bl_nxt;
      tml_r       <= tml_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_text_r  <= is_text_nxt;
    ch_r       <= ch_nxt;
    len_r      <= len_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: design/kmp_checker.sv
`default_nettype none

module kmp_checker
  import kmp_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire kmp_out_t out_data
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STAT_OK || out_data.status == STAT_FULL ||
                   out_data.status == STAT_EMPTY))
    else $error("unknown status code");

  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.match_found |-> out_data.status == STAT_OK)
    else $error("match reported with error status");

  a_no_match_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.match_found |-> out_data.match_start == '0)
    else $error("start index without a match");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind kmp_stream_matcher kmp_checker u_kmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
